/* rtl/itr_pkg.sv */
// Shared types, constants and symbol helpers for the radix digit converter.
package itr_pkg;

  localparam int MAX_BASE    = 16;
  localparam int MAX_DIGITS  = 32;
  localparam int IDX_W       = $clog2(MAX_DIGITS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DEL   = 8'd127;

  typedef enum logic [1:0] {
    REG_BASE_LENGTH  = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } itr_reg_e;

  typedef struct packed {
    logic [4:0]  base_length;
    logic [63:0] symbols_low;
    logic [63:0] symbols_high;
  } itr_cfg_t;

  typedef struct packed {
    logic        err;
    logic        neg;
    logic [31:0] mag;
  } itr_item_t;

  function automatic logic [7:0] sym_at(input itr_cfg_t cfg, input logic [3:0] idx);
    logic [127:0] tab;
    tab = {cfg.symbols_high, cfg.symbols_low};
    return tab[{idx, 3'b000} +: 8];
  endfunction

endpackage

/* rtl/itr_front.sv */
// Front end: configuration registers, symbol set check, input capture and classification.
module itr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_number,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output itr_pkg::itr_cfg_t  cfg,
  output logic               push,
  output itr_pkg::itr_item_t push_item,
  input  logic               q_full
);
  import itr_pkg::*;

  itr_cfg_t    cfg_r;
  logic        set_ok_r;
  logic        set_ok_nxt;
  logic        stg_vld_r;
  logic        stg_vld_nxt;
  logic [31:0] stg_num_r;
  logic        accept;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_LENGTH:  cfg_r.base_length  <= cfg_data[4:0];
        REG_SYMBOLS_LOW:  cfg_r.symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: cfg_r.symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // symbol set check, all pairs in parallel
  always_comb begin
    logic [7:0] ci;
    logic       act_i;
    set_ok_nxt = (cfg_r.base_length >= 5'd2) && (cfg_r.base_length <= 5'(MAX_BASE));
    for (int i = 0; i < 16; i++) begin
      ci    = sym_at(cfg_r, 4'(i));
      act_i = 5'(i) < cfg_r.base_length;
      if (act_i && (ci == CHAR_PLUS || ci == CHAR_MINUS || ci <= CHAR_SPACE ||
                    ci >= CHAR_DEL)) begin
        set_ok_nxt = 1'b0;
      end
      for (int j = i + 1; j < 16; j++) begin
        if (act_i && (5'(j) < cfg_r.base_length) && (sym_at(cfg_r, 4'(j)) == ci)) begin
          set_ok_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_ok_r <= 1'b0;
    end else begin
      set_ok_r <= set_ok_nxt;
    end
  end

  assign busy   = stg_vld_r && q_full;
  assign accept = start && !busy;
  assign push   = stg_vld_r && !q_full;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (accept) begin
      stg_vld_nxt = 1'b1;
    end else if (push) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_num_r <= in_number;
    end
  end

  assign push_item.err = !set_ok_r;
  assign push_item.neg = stg_num_r[31];
  assign push_item.mag = stg_num_r[31] ? (32'd0 - stg_num_r) : stg_num_r;

endmodule

/* rtl/itr_fifo.sv */
// Short item queue between the front end and the digit engine.
module itr_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  itr_pkg::itr_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output itr_pkg::itr_item_t pop_item
);
  import itr_pkg::*;

  itr_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic [QPTR_W:0]   cnt_nxt;

  assign full      = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue pop while empty");

endmodule

/* rtl/itr_back.sv */
// Digit engine: chunked long division by the radix, digit stack, byte emission.
module itr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  itr_pkg::itr_cfg_t  cfg,
  input  logic               q_valid,
  input  itr_pkg::itr_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  output logic [7:0]         out_char,
  output logic               out_last,
  output logic               out_base_error
);
  import itr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_PREP = 4'b0100,
    S_EMIT = 4'b1000
  } itr_state_t;

  itr_state_t       state_r, state_nxt;
  logic [31:0]      quo_r, quo_nxt;
  logic [3:0]       rem_r, rem_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic             neg_r, neg_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       oc_r, oc_nxt;
  logic             ol_r, ol_nxt;
  logic             oe_r, oe_nxt;

  logic [3:0]       stack [MAX_DIGITS];
  logic [3:0]       rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             st_we;
  logic [CNT_W-1:0] cnt_dec;

  logic [4:0]       div_rem;
  logic [7:0]       div_qb;
  logic [4:0]       radix;

  assign radix   = cfg.base_length;
  assign cnt_dec = cnt_r - CNT_W'(1);

  // eight restoring steps per cycle, top byte of the running quotient
  always_comb begin
    div_rem = {1'b0, rem_r};
    div_qb  = '0;
    for (int k = 0; k < 8; k++) begin
      div_rem = {div_rem[3:0], quo_r[31-k]};
      if (div_rem >= radix) begin
        div_rem    = div_rem - radix;
        div_qb[7-k] = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    neg_nxt   = neg_r;
    ov_nxt    = 1'b0;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    oe_nxt    = oe_r;
    pop       = 1'b0;
    st_we     = 1'b0;
    rd_addr   = ptr_r - 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_item.err) begin
            ov_nxt = 1'b1;
            oc_nxt = 8'd0;
            ol_nxt = 1'b1;
            oe_nxt = 1'b1;
          end else begin
            quo_nxt   = q_item.mag;
            neg_nxt   = q_item.neg;
            rem_nxt   = '0;
            step_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        quo_nxt  = {quo_r[23:0], div_qb};
        rem_nxt  = div_rem[3:0];
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd3) begin
          st_we   = 1'b1;
          rem_nxt = '0;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (quo_nxt == '0 || cnt_r == CNT_W'(MAX_DIGITS - 1)) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        rd_addr = cnt_dec[IDX_W-1:0];
        ptr_nxt = cnt_dec[IDX_W-1:0];
        if (neg_r) begin
          ov_nxt = 1'b1;
          oc_nxt = CHAR_MINUS;
          ol_nxt = 1'b0;
          oe_nxt = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ov_nxt  = 1'b1;
        oc_nxt  = sym_at(cfg, rd_data_r);
        ol_nxt  = ptr_r == '0;
        oe_nxt  = 1'b0;
        ptr_nxt = ptr_r - 1'b1;
        if (ptr_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      quo_r   <= '0;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      quo_r   <= quo_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    ptr_r <= ptr_nxt;
    neg_r <= neg_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
    oe_r  <= oe_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stack[cnt_r[IDX_W-1:0]] <= div_rem[3:0];
    end
    rd_data_r <= stack[rd_addr];
  end

  assign out_valid      = ov_r;
  assign out_char       = oc_r;
  assign out_last       = ol_r;
  assign out_base_error = oe_r;

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_base_error) |-> (out_last && out_char == 8'd0))
    else $error("error beat malformed");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count overrun");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_EMIT && ptr_r == '0) |=> (state_r == S_IDLE && out_valid && out_last))
    else $error("final digit did not close the number");

endmodule

/* rtl/integer_to_radix_digits.sv */
// Top level of the signed integer to radix digit string converter.
// An item is taken when start is high and busy is low; the symbol set is checked in the
// front end and each number is queued for the digit engine, which divides by the radix
// eight quotient bits per cycle. A valid number gives up to 32 digits in radix 2 and up to
// 10 for decimal; an invalid symbol set gives a single error beat. Output beats appear on
// out_valid for one cycle each and cannot be stalled; the front end accepts new numbers
// while the engine works until its two-entry queue and capture register fill.
module integer_to_radix_digits (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_number,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               out_valid,
  output logic [7:0]         out_char,
  output logic               out_last,
  output logic               out_base_error
);
  import itr_pkg::*;

  itr_cfg_t  cfg;
  itr_item_t push_item;
  itr_item_t pop_item;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  itr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_number (in_number),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  itr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_item  (pop_item)
  );

  itr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (pop_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_base_error (out_base_error)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for integer_to_radix_digits: directed table, then random numbers.
`timescale 1ns / 100ps

module tb_top;
  import itr_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } digit_beat_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_NUM, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    itr_reg_e    idx;
    logic [63:0] data;
    logic [31:0] num;
    digit_beat_t want;
  } stim_row_t;

  typedef enum {
    FAULT_NONE, FAULT_RADIX, FAULT_PLUS, FAULT_MINUS, FAULT_LOW, FAULT_HIGH, FAULT_DUP
  } set_fault_e;

  localparam digit_beat_t ERR_BEAT   = '{8'd0, 1'b1, 1'b1};
  localparam int          SETTLE_CYC = 8;
  localparam int          TAIL_CYC   = 170;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_number;
  logic               cfg_valid;
  logic               cfg_ready;
  itr_reg_e           cfg_index;
  logic [63:0]        cfg_data;
  logic               out_valid;
  logic [7:0]         out_char;
  logic               out_last;
  logic               out_base_error;

  logic [4:0]  cur_radix;
  logic [63:0] cur_sym_lo;
  logic [63:0] cur_sym_hi;

  digit_beat_t beats_due[$];
  digit_beat_t due_beat;
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;

  integer_to_radix_digits dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_number      (in_number),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_base_error (out_base_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("integer_to_radix_digits verification failed");
    $finish;
  end

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [127:0] tab;
    tab = {cur_sym_hi, cur_sym_lo};
    return tab[int'(d) * 8 +: 8];
  endfunction

  function automatic bit symbol_set_ok();
    logic [7:0] c;
    if (cur_radix < 2 || cur_radix > MAX_BASE) return 1'b0;
    for (int i = 0; i < cur_radix; i++) begin
      c = glyph(i[3:0]);
      if (c == CHAR_PLUS || c == CHAR_MINUS || c <= CHAR_SPACE || c >= CHAR_DEL) return 1'b0;
      for (int j = i + 1; j < cur_radix; j++)
        if (glyph(j[3:0]) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_digits(input logic [31:0] raw);
    logic [31:0] mag;
    logic [31:0] radix_w;
    logic [3:0]  digs [MAX_DIGITS];
    int          cnt;
    if (!symbol_set_ok()) begin
      beats_due.push_back(ERR_BEAT);
      return;
    end
    radix_w = {27'd0, cur_radix};
    mag = raw[31] ? (32'd0 - raw) : raw;
    cnt = 0;
    do begin
      digs[cnt] = 4'(mag % radix_w);
      cnt++;
      mag = mag / radix_w;
    end while (mag != 0 && cnt < MAX_DIGITS);
    if (raw[31]) beats_due.push_back(digit_beat_t'{CHAR_MINUS, 1'b0, 1'b0});
    while (cnt > 0) begin
      cnt--;
      beats_due.push_back(digit_beat_t'{glyph(digs[cnt]), cnt == 0, 1'b0});
    end
  endfunction

  function automatic logic [31:0] pick_number();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'd0;
          default: v = 32'd1;
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 300);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      3, 4, 5: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (beats_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat char %h last %b err %b",
                 $time, out_char, out_last, out_base_error);
      end else begin
        due_beat = beats_due.pop_front();
        if ({out_char, out_last, out_base_error} !== due_beat) begin
          mismatch_count++;
          $display("%0t: expected char %h last %b err %b, got char %h last %b err %b",
                   $time, due_beat.ch, due_beat.last, due_beat.err,
                   out_char, out_last, out_base_error);
        end
      end
    end
  end

  task automatic send_number(input logic [31:0] num, input bit typed, input digit_beat_t want);
    bit took;
    cfg_valid <= 1'b0;
    start     <= 1'b1;
    in_number <= num;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    if (typed) beats_due.push_back(want);
    else predict_digits(num);
  endtask

  task automatic write_reg(input itr_reg_e idx, input logic [63:0] data);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    case (idx)
      REG_BASE_LENGTH:  cur_radix  = data[4:0];
      REG_SYMBOLS_LOW:  cur_sym_lo = data;
      REG_SYMBOLS_HIGH: cur_sym_hi = data;
      default: ;
    endcase
  endtask

  // idle the sender until every expected beat is out
  task automatic settle();
    start <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic hold_off(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
  endtask

  task automatic load_random_set();
    logic [7:0]   tab [16];
    logic [255:0] taken;
    logic [4:0]   radix;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  lenword;
    set_fault_e   fault;
    int           pos;
    int           other;
    int           c;
    int           r;
    taken = '0;
    radix = 5'($urandom_range(2, 16));
    for (int i = 0; i < 16; i++) begin
      if (i < radix) begin
        do c = $urandom_range(33, 126);
        while (taken[c] || c == CHAR_PLUS || c == CHAR_MINUS);
        taken[c] = 1'b1;
        tab[i] = 8'(c);
      end else begin
        tab[i] = 8'($urandom_range(0, 255));
      end
    end
    fault = ($urandom_range(0, 9) < 7) ? FAULT_NONE : set_fault_e'($urandom_range(1, 6));
    pos = $urandom_range(0, radix - 1);
    case (fault)
      FAULT_RADIX: begin
        r = $urandom_range(0, 16);
        radix = 5'((r < 2) ? r : r + 15);
      end
      FAULT_PLUS:  tab[pos] = CHAR_PLUS;
      FAULT_MINUS: tab[pos] = CHAR_MINUS;
      FAULT_LOW:   tab[pos] = 8'($urandom_range(0, 32));
      FAULT_HIGH:  tab[pos] = 8'($urandom_range(127, 255));
      FAULT_DUP: begin
        other = (pos + 1 + $urandom_range(0, radix - 2)) % radix;
        tab[pos] = tab[other];
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      lo[i * 8 +: 8] = tab[i];
      hi[i * 8 +: 8] = tab[i + 8];
    end
    lenword = {$urandom, $urandom};
    lenword[4:0] = radix;
    settle();
    write_reg(REG_SYMBOLS_LOW, lo);
    write_reg(REG_BASE_LENGTH, lenword);
    write_reg(REG_SYMBOLS_HIGH, hi);
  endtask

  function automatic void cfg_row(input itr_reg_e idx, input logic [63:0] data);
    directed_rows.push_back(stim_row_t'{ROW_CFG, idx, data, 32'd0, ERR_BEAT});
  endfunction

  function automatic void num_row(input logic [31:0] num);
    directed_rows.push_back(stim_row_t'{ROW_NUM, REG_BASE_LENGTH, 64'd0, num, ERR_BEAT});
  endfunction

  function automatic void typed_row(input logic [31:0] num, input digit_beat_t want);
    directed_rows.push_back(stim_row_t'{ROW_TYPED, REG_BASE_LENGTH, 64'd0, num, want});
  endfunction

  initial begin
    stim_row_t row;
    int        pct;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_number  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_BASE_LENGTH;
    cfg_data   = '0;
    cur_radix  = '0;
    cur_sym_lo = '0;
    cur_sym_hi = '0;

    // reset state: empty symbol set
    typed_row(32'd5, ERR_BEAT);
    typed_row(32'h8000_0000, ERR_BEAT);
    cfg_row(REG_SYMBOLS_LOW, 64'h3736_3534_3332_3130);
    cfg_row(REG_SYMBOLS_HIGH, 64'h4645_4443_4241_3938);
    typed_row(32'h7FFF_FFFF, ERR_BEAT);
    // decimal
    cfg_row(REG_BASE_LENGTH, 64'd10);
    typed_row(32'd0, '{8'h30, 1'b1, 1'b0});
    typed_row(32'd9, '{8'h39, 1'b1, 1'b0});
    num_row(32'h7FFF_FFFF);
    num_row(32'h8000_0000);
    num_row(32'hFFFF_FFFF);
    // binary, longest output
    cfg_row(REG_BASE_LENGTH, 64'd2);
    num_row(32'h8000_0000);
    num_row(32'h7FFF_FFFF);
    typed_row(32'd1, '{8'h31, 1'b1, 1'b0});
    // hex
    cfg_row(REG_BASE_LENGTH, 64'd16);
    num_row(32'hDEAD_BEEF);
    typed_row(32'd15, '{8'h46, 1'b1, 1'b0});
    // bad radix
    cfg_row(REG_BASE_LENGTH, 64'd1);
    typed_row(32'd1, ERR_BEAT);
    cfg_row(REG_BASE_LENGTH, 64'd17);
    typed_row(32'd3, ERR_BEAT);
    cfg_row(REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    typed_row(32'd3, ERR_BEAT);
    // bad symbols in the top slot
    cfg_row(REG_BASE_LENGTH, 64'd16);
    cfg_row(REG_SYMBOLS_HIGH, 64'h2B45_4443_4241_3938);
    typed_row(32'd7, ERR_BEAT);
    cfg_row(REG_SYMBOLS_HIGH, 64'h2D45_4443_4241_3938);
    typed_row(32'd7, ERR_BEAT);
    cfg_row(REG_SYMBOLS_HIGH, 64'h3045_4443_4241_3938);
    typed_row(32'd7, ERR_BEAT);
    cfg_row(REG_SYMBOLS_HIGH, 64'h2045_4443_4241_3938);
    typed_row(32'd7, ERR_BEAT);
    cfg_row(REG_SYMBOLS_HIGH, 64'h7F45_4443_4241_3938);
    typed_row(32'd7, ERR_BEAT);
    // printable limits are legal
    cfg_row(REG_SYMBOLS_LOW, 64'h3736_3534_3332_3121);
    cfg_row(REG_SYMBOLS_HIGH, 64'h7E45_4443_4241_3938);
    typed_row(32'd0, '{8'h21, 1'b1, 1'b0});
    num_row(32'hFFFF_FFF0);
    // junk beyond the radix is ignored
    cfg_row(REG_BASE_LENGTH, 64'd3);
    cfg_row(REG_SYMBOLS_HIGH, 64'h2B2D_00FF_7F20_2B2D);
    num_row(32'hFFFF_FFFB);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_CFG: begin
          settle();
          write_reg(row.idx, row.data);
        end
        ROW_NUM:   send_number(row.num, 1'b0, row.want);
        default:   send_number(row.num, 1'b1, row.want);
      endcase
    end

    for (int phase = 0; phase < 4; phase++) begin
      pct = (phase == 1) ? 86 : (phase == 3) ? 18 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        load_random_set();
        for (int k = 0; k < 25; k++) begin
          if ($urandom_range(0, 99) < 4) settle();
          else hold_off(pct);
          send_number(pick_number(), 1'b0, ERR_BEAT);
        end
      end
    end

    settle();
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatch_count == 0 && beats_due.size() == 0) begin
      $display("integer_to_radix_digits verification clean");
    end else begin
      $display("integer_to_radix_digits verification failed");
    end
    $finish;
  end

endmodule

/* integer_to_radix_digits.f */
rtl/itr_pkg.sv
rtl/itr_front.sv
rtl/itr_fifo.sv
rtl/itr_back.sv
rtl/integer_to_radix_digits.sv
tb/tb_top.sv
